[hw/rtl/kth_pkg.sv]
// ----------------------------------------------------------------------------
// kth_pkg
// shared constants and types for the k-th largest stream tracker
// ----------------------------------------------------------------------------
`default_nettype none

package kth_pkg;

    // default sizing
    localparam int MAX_K_DEF   = 64;
    localparam int VALUE_W_DEF = 16;

    // register file
    localparam int RANK_W     = 7;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register index as seen in paddr[2]
    localparam logic REG_RANK_K = 1'b0;

    localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(1);

    // per-cell control from the chain controller
    typedef struct packed {
        logic load;      // transaction accepted this cycle
        logic occupied;  // cell holds a retained value
    } t_cell_ctl;

endpackage

`default_nettype wire

[hw/rtl/kth_largest_stream_tracker.sv]
// ----------------------------------------------------------------------------
// kth_largest_stream_tracker
// keeps the k largest values of a signed stream in a sorted chain of cells
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after its input transaction is accepted
// throughput: one transaction per cycle while o_stall is low, each chain insert done on accept
// every cell compares and shifts in parallel, the tail slot is read at update
// reset: held count cleared, rank_k set to 1, cell contents left undefined
`default_nettype none

module kth_largest_stream_tracker #(
    parameter int MAX_K   = kth_pkg::MAX_K_DEF,
    parameter int VALUE_W = kth_pkg::VALUE_W_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // apb register port
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [kth_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire [kth_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [kth_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    // input stream
    input  wire                               i_valid,
    input  wire signed [VALUE_W-1:0]          i_value,
    output logic                              o_stall,
    // result stream
    output logic                              o_valid,
    output logic signed [VALUE_W-1:0]         o_kth_value,
    output logic                              o_full_res,
    input  wire                               i_stall
);

    // count runs 0..MAX_K, slot index 0..MAX_K-1
    localparam int CNT_W = $clog2(MAX_K + 1);
    localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KW    = (CNT_W > kth_pkg::RANK_W) ? CNT_W : kth_pkg::RANK_W;

    logic [kth_pkg::RANK_W-1:0] r_rank;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic                       r_out_valid;
    logic signed [VALUE_W-1:0]  r_out_value;
    logic                       r_out_full;

    logic                       in_accept;
    logic                       cfg_write;
    logic [KW-1:0]              k_wide;
    logic [CNT_W-1:0]           k_eff;
    logic [CNT_W:0]             count_inc;
    logic [CNT_W-1:0]           tail_pos;

    // chain wiring
    logic signed [VALUE_W-1:0]  cell_value [MAX_K];
    logic signed [VALUE_W-1:0]  cell_next  [MAX_K];
    logic                       cell_gt    [MAX_K];

    // ------------------------------------------------------------------------
    // register port, writes land on the access phase
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == kth_pkg::REG_RANK_K);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= kth_pkg::RANK_RESET;
        end else if (cfg_write) begin
            r_rank <= pwdata[kth_pkg::RANK_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            kth_pkg::REG_RANK_K: prdata[kth_pkg::RANK_W-1:0] = r_rank;
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // effective rank: zero acts as one, clamp at chain length
    // ------------------------------------------------------------------------
    always_comb begin
        if (r_rank == '0) begin
            k_wide = KW'(1);
        end else begin
            k_wide = KW'(r_rank);
        end
        if (k_wide > KW'(MAX_K)) begin
            k_wide = KW'(MAX_K);
        end
        k_eff = k_wide[CNT_W-1:0];
    end

    // ------------------------------------------------------------------------
    // handshake: output register frees when it drains this cycle
    // ------------------------------------------------------------------------
    assign o_stall   = r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;

    // new held count is min(count + 1, k); a lowered rank trims the tail here
    always_comb begin
        count_inc = {1'b0, r_count} + (CNT_W + 1)'(1);
        if (count_inc > {1'b0, k_eff}) begin
            n_count = k_eff;
        end else begin
            n_count = count_inc[CNT_W-1:0];
        end
        tail_pos = n_count - CNT_W'(1);
    end

    // ------------------------------------------------------------------------
    // cell chain, head holds the largest value
    // ------------------------------------------------------------------------
    for (genvar g = 0; g < MAX_K; g++) begin : g_cell
        kth_pkg::t_cell_ctl        ctl;
        logic signed [VALUE_W-1:0] prev_value;
        logic                      prev_gt;

        assign ctl.load     = in_accept;
        assign ctl.occupied = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            // head sees a virtual neighbor at the top of the range
            assign prev_value = {1'b0, {(VALUE_W-1){1'b1}}};
            assign prev_gt    = 1'b0;
        end else begin : g_body
            assign prev_value = cell_value[g-1];
            assign prev_gt    = cell_gt[g-1];
        end

        kth_cell #(
            .VALUE_W (VALUE_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_value      (i_value),
            .i_prev_value (prev_value),
            .i_prev_gt    (prev_gt),
            .o_value      (cell_value[g]),
            .o_next       (cell_next[g]),
            .o_gt         (cell_gt[g])
        );
    end

    // ------------------------------------------------------------------------
    // held count and result register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_count <= n_count;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // smallest retained value sits at the new tail of the chain
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_value <= cell_next[tail_pos[IDX_W-1:0]];
            r_out_full  <= (n_count == k_eff);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_kth_value = r_out_value;
    assign o_full_res  = r_out_full;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_K))
        else $error("kth: held count beyond chain length");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (o_valid && (r_count != '0)))
        else $error("kth: accepted transaction produced no result");

    a_full_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> (n_count <= k_eff))
        else $error("kth: held count exceeds rank");
`endif

endmodule

`default_nettype wire

[hw/rtl/kth_cell.sv]
// ----------------------------------------------------------------------------
// kth_cell
// one slot of the descending sorted chain, shifts toward the tail on insert
// ----------------------------------------------------------------------------
`default_nettype none

module kth_cell #(
    parameter int VALUE_W = kth_pkg::VALUE_W_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  kth_pkg::t_cell_ctl        i_ctl,
    input  wire signed [VALUE_W-1:0]  i_value,
    input  wire signed [VALUE_W-1:0]  i_prev_value,
    input  wire                       i_prev_gt,
    output logic signed [VALUE_W-1:0] o_value,
    output logic signed [VALUE_W-1:0] o_next,
    output logic                      o_gt
);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;

    // empty slot counts as minus infinity
    always_comb begin
        o_gt = !i_ctl.occupied || (i_value > r_value);
        if (!o_gt) begin
            n_value = r_value;
        end else if (i_prev_gt) begin
            n_value = i_prev_value;
        end else begin
            n_value = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;
    assign o_next  = n_value;

`ifndef SYNTHESIS
    // an occupied slot never exceeds its neighbor toward the head
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.occupied |-> (i_prev_value >= r_value))
        else $error("kth_cell: chain out of order");
`endif

endmodule

`default_nettype wire
